FILE: hw/rtl/dtop_pkg.sv
// ----------------------------------------------------------------------------
// dtop_pkg
// types and constants shared by the der tlv / oid parser
// ----------------------------------------------------------------------------
package dtop_pkg;

	localparam int unsigned MaxLengthOctets = 8;
	localparam logic [7:0]  OidTag          = 8'h06;
	localparam logic [31:0] FirstArcSplit   = 32'd40;
	localparam logic [31:0] FirstArcLimit   = 32'd80;

	typedef enum logic [1:0] {
		PhTag     = 2'd0,
		PhLen     = 2'd1,
		PhLong    = 2'd2,
		PhContent = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KindHeader  = 2'd0,
		KindContent = 2'd1,
		KindArc     = 2'd2,
		KindError   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ErrNone      = 2'd0,
		ErrLenTooBig = 2'd1,
		ErrTruncated = 2'd2,
		ErrUnused    = 2'd3
	} err_t;

	typedef enum logic {
		RegBufferLength = 1'b0,
		RegDecodeOid    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tag;
		logic [63:0] object_length;
		logic [7:0]  content_byte;
		logic [31:0] arc_value;
		err_t        error_code;
		logic        last_of_run;
	} res_t;

endpackage

FILE: hw/rtl/dtop_ifs.sv
// ----------------------------------------------------------------------------
// dtop channel interfaces
// byte input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface dtop_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_buffer;

	modport source (output valid, output data_byte, output first_of_buffer, input ready);
	modport sink   (input valid, input data_byte, input first_of_buffer, output ready);
endinterface

interface dtop_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  tag;
	logic [63:0] object_length;
	logic [7:0]  content_byte;
	logic [31:0] arc_value;
	logic [1:0]  error_code;
	logic        last_of_run;

	modport source (output valid, output kind, output tag, output object_length,
		output content_byte, output arc_value, output error_code, output last_of_run,
		input ready);
	modport sink   (input valid, input kind, input tag, input object_length,
		input content_byte, input arc_value, input error_code, input last_of_run,
		output ready);
endinterface

FILE: hw/rtl/der_tlv_oid_parser.sv
// ----------------------------------------------------------------------------
// der_tlv_oid_parser
// byte-serial der tlv parser with header, content byte and oid arc results
// ----------------------------------------------------------------------------
// channel   dir  transaction
// bytes     in   one buffer byte with restart flag
// results   out  one header, content byte, oid arc or error
// cfg_*     in   register write, index 0 buffer_length, 1 decode_oid
//
// one byte is taken per cycle while the queue has room; each byte is parsed in the cycle it is taken
// and its zero to two results enter a four-entry result queue
// bytes are taken while the queue holds two or fewer results; even with results
// always ready, bytes with two results can push the queue past two, so bytes can wait
// results stalls back up into the queue and then bytes; reset clears the
// parser state, the queue and the registers to their defaults
// ----------------------------------------------------------------------------
module der_tlv_oid_parser (
	input  logic               clk,
	input  logic               arst_n,
	dtop_byte_if.sink          bytes,
	dtop_res_if.source         results,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata
);
	import dtop_pkg::*;

	logic [31:0] buf_len_q;
	logic        dec_oid_q;

	phase_t      phase_q, phase_d;
	logic [31:0] off_q, off_d;
	logic [7:0]  tag_q, tag_d;
	logic [63:0] len_q, len_d;
	logic [3:0]  oct_q, oct_d;
	logic [63:0] cont_q, cont_d;
	logic [31:0] subid_q, subid_d;
	logic        first_q, first_d;
	logic        halt_q, halt_d;

	res_t        queue_q [4];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;

	logic        acc, pop;
	logic [1:0]  n;
	res_t        r0, r1;

	// parse scratch
	phase_t      e_phase;
	logic [31:0] e_off;
	logic        e_halt;
	logic [31:0] s, x, y;
	logic        do_len_done, do_fail, do_hdr, do_byte, do_arc1, do_arc2;
	err_t        fail_code;
	logic [63:0] room;
	logic [6:0]  cnt;

	assign bytes.ready = (cnt_q <= 3'd2);
	assign acc = bytes.valid & bytes.ready;
	assign results.valid = (cnt_q != 3'd0);
	assign pop = results.valid & results.ready;

	always_comb begin
		e_phase = bytes.first_of_buffer ? PhTag : phase_q;
		e_off   = bytes.first_of_buffer ? 32'd0 : off_q;
		e_halt  = bytes.first_of_buffer ? 1'b0 : halt_q;
		phase_d = e_phase;
		off_d   = e_off;
		halt_d  = e_halt;
		subid_d = bytes.first_of_buffer ? 32'd0 : subid_q;
		first_d = bytes.first_of_buffer ? 1'b1 : first_q;
		tag_d   = tag_q;
		len_d   = len_q;
		oct_d   = oct_q;
		cont_d  = cont_q;
		do_len_done = 1'b0;
		do_fail   = 1'b0;
		do_hdr    = 1'b0;
		do_byte   = 1'b0;
		do_arc1   = 1'b0;
		do_arc2   = 1'b0;
		fail_code = ErrNone;
		s = 32'd0;
		x = 32'd0;
		y = 32'd0;
		cnt = bytes.data_byte[6:0];
		room = 64'd0;

		if (!e_halt) begin
			case (e_phase)
				PhTag: begin
					if (e_off < buf_len_q) begin
						tag_d = bytes.data_byte;
						len_d = 64'd0;
						if ((buf_len_q - e_off) < 32'd2) begin
							do_fail   = 1'b1;
							fail_code = ErrTruncated;
						end else begin
							off_d   = e_off + 32'd1;
							phase_d = PhLen;
						end
					end
				end
				default: begin
					if (e_off >= buf_len_q) begin
						do_fail   = 1'b1;
						fail_code = ErrTruncated;
					end else begin
						off_d = e_off + 32'd1;
						if (e_phase == PhLen) begin
							if (bytes.data_byte[7]) begin
								len_d = 64'd0;
								if ({25'd0, cnt} > 32'(MaxLengthOctets)) begin
									do_fail   = 1'b1;
									fail_code = ErrLenTooBig;
								end else if (cnt == 7'd0) begin
									do_len_done = 1'b1;
								end else begin
									oct_d   = cnt[3:0];
									phase_d = PhLong;
								end
							end else begin
								len_d = {57'd0, cnt};
								do_len_done = 1'b1;
							end
						end else if (e_phase == PhLong) begin
							len_d = {len_q[55:0], bytes.data_byte};
							oct_d = oct_q - 4'd1;
							if (oct_d == 4'd0) begin
								do_len_done = 1'b1;
							end
						end else begin
							if (dec_oid_q && (tag_q == OidTag)) begin
								s = {subid_d[24:0], cnt};
								subid_d = s;
								if (!bytes.data_byte[7]) begin
									if (first_d) begin
										if (s < FirstArcLimit) begin
											x = (s >= FirstArcSplit) ? 32'd1 : 32'd0;
											y = (s >= FirstArcSplit) ? (s - FirstArcSplit) : s;
										end else begin
											x = 32'd2;
											y = s - FirstArcLimit;
										end
										do_arc2 = 1'b1;
										first_d = 1'b0;
									end else begin
										x = s;
										do_arc1 = 1'b1;
									end
									subid_d = 32'd0;
								end
							end else begin
								do_byte = 1'b1;
							end
							cont_d = cont_q - 64'd1;
							if (cont_d == 64'd0) begin
								phase_d = PhTag;
								subid_d = 32'd0;
								first_d = 1'b1;
							end
						end
					end
				end
			endcase
		end

		if (do_len_done) begin
			room = {32'd0, buf_len_q} - {32'd0, off_d};
			if (len_d > room) begin
				do_fail   = 1'b1;
				fail_code = ErrTruncated;
			end else begin
				do_hdr  = 1'b1;
				cont_d  = len_d;
				subid_d = 32'd0;
				first_d = 1'b1;
				phase_d = (len_d == 64'd0) ? PhTag : PhContent;
			end
		end
		if (do_fail) begin
			halt_d = 1'b1;
		end

		r0 = '0;
		r1 = '0;
		r0.tag = tag_d;
		r0.object_length = len_d;
		r0.last_of_run = 1'b1;
		r1.tag = tag_d;
		r1.object_length = len_d;
		r1.last_of_run = 1'b1;
		r1.kind = KindArc;
		r1.arc_value = y;
		n = 2'd0;
		if (do_fail) begin
			r0.kind = KindError;
			r0.error_code = fail_code;
			n = 2'd1;
		end else if (do_hdr) begin
			r0.kind = KindHeader;
			n = 2'd1;
		end else if (do_byte) begin
			r0.kind = KindContent;
			r0.content_byte = bytes.data_byte;
			n = 2'd1;
		end else if (do_arc1 || do_arc2) begin
			r0.kind = KindArc;
			r0.arc_value = x;
			r0.last_of_run = do_arc1;
			n = do_arc2 ? 2'd2 : 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_len_q <= 32'd0;
			dec_oid_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				RegBufferLength: buf_len_q <= cfg_wdata;
				RegDecodeOid:    dec_oid_q <= cfg_wdata[0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhTag;
			off_q   <= 32'd0;
			tag_q   <= 8'd0;
			len_q   <= 64'd0;
			oct_q   <= 4'd0;
			cont_q  <= 64'd0;
			subid_q <= 32'd0;
			first_q <= 1'b1;
			halt_q  <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			off_q   <= off_d;
			tag_q   <= tag_d;
			len_q   <= len_d;
			oct_q   <= oct_d;
			cont_q  <= cont_d;
			subid_q <= subid_d;
			first_q <= first_d;
			halt_q  <= halt_d;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (acc && (n != 2'd0)) begin
			queue_q[wr_q] <= r0;
		end
		if (acc && (n == 2'd2)) begin
			queue_q[wr_q + 2'd1] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (acc) begin
				wr_q <= wr_q + n;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + (acc ? {1'b0, n} : 3'd0) - {2'd0, pop};
		end
	end

	assign results.kind          = queue_q[rd_q].kind;
	assign results.tag           = queue_q[rd_q].tag;
	assign results.object_length = queue_q[rd_q].object_length;
	assign results.content_byte  = queue_q[rd_q].content_byte;
	assign results.arc_value     = queue_q[rd_q].arc_value;
	assign results.error_code    = queue_q[rd_q].error_code;
	assign results.last_of_run   = queue_q[rd_q].last_of_run;

endmodule

FILE: verif/tb_der_tlv_oid_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_der_tlv_oid_parser
// self-checking bench for the der tlv / oid parser: a directed table of
// boundary buffers, then random buffers of tlv objects under several
// register settings, results checked against the table or an in-bench decoder model
// ----------------------------------------------------------------------------
module tb_der_tlv_oid_parser;
	import dtop_pkg::*;

	localparam int DirRows    = 31;
	localparam int RandBytes  = 1500;
	localparam int PhaseBytes = 120;
	localparam int Settle     = 8;
	localparam int CycleLimit = 400000;

	typedef enum logic {OpByte, OpWrite} row_op_t;
	typedef enum logic [2:0] {ChkPred, ChkNone, ChkHeader, ChkTrunc, ChkTooBig} chk_t;

	typedef struct {
		row_op_t     op;
		reg_idx_t    idx;
		logic        first;
		logic [31:0] val;
		chk_t        chk;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_wdata;

	dtop_byte_if byte_ch ();
	dtop_res_if  res_ch ();

	der_tlv_oid_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (byte_ch),
		.results   (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder model state and registers
	logic [31:0] pr_buf_len   = '0;
	logic        pr_oid_on    = 1'b1;
	phase_t      st_phase     = PhTag;
	logic [31:0] st_off       = '0;
	logic [7:0]  st_tag       = '0;
	logic [63:0] st_len       = '0;
	logic [3:0]  st_octs      = '0;
	logic [63:0] st_left      = '0;
	logic [31:0] st_subid     = '0;
	logic        st_first_arc = 1'b1;
	logic        st_halted    = 1'b0;

	res_t        pending_results [$];
	chk_t        row_checks [$];
	logic [7:0]  buf_q [$];

	int src_max = 10;
	int snk_max = 10;
	int unsigned n_fail, n_bytes, n_parsed, n_results, n_writes, n_cycles;
	int unsigned kind_seen [4];

	dir_row_t dir_tbl [DirRows] = '{
		'{OpWrite, RegBufferLength, 1'b0, 32'd0,        ChkPred},
		'{OpByte,  RegBufferLength, 1'b1, 32'h30,       ChkNone},
		'{OpWrite, RegBufferLength, 1'b0, 32'd1,        ChkPred},
		'{OpByte,  RegBufferLength, 1'b1, 32'h02,       ChkTrunc},
		'{OpByte,  RegBufferLength, 1'b0, 32'hFF,       ChkNone},
		'{OpWrite, RegBufferLength, 1'b0, 32'd2,        ChkPred},
		'{OpByte,  RegBufferLength, 1'b1, 32'h04,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'h81,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'h00,       ChkTrunc},
		'{OpWrite, RegBufferLength, 1'b0, 32'hFFFFFFFF, ChkPred},
		'{OpWrite, RegDecodeOid,    1'b0, 32'hFFFFFFFF, ChkPred},
		'{OpByte,  RegBufferLength, 1'b1, 32'h06,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'h04,       ChkHeader},
		'{OpByte,  RegBufferLength, 1'b0, 32'hD0,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'h0F,       ChkPred},
		'{OpByte,  RegBufferLength, 1'b0, 32'h2A,       ChkPred},
		'{OpByte,  RegBufferLength, 1'b0, 32'h81,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'h30,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'h89,       ChkTooBig},
		'{OpByte,  RegBufferLength, 1'b1, 32'h04,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'h80,       ChkHeader},
		'{OpByte,  RegBufferLength, 1'b0, 32'h06,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'h88,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'hFF,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'hFF,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'hFF,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'hFF,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'hFF,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'hFF,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'hFF,       ChkNone},
		'{OpByte,  RegBufferLength, 1'b0, 32'hFF,       ChkTrunc}
	};

	function automatic res_t mk_res(kind_t k, logic [7:0] cb, logic [31:0] arc, err_t e);
		res_t r;
		r.kind          = k;
		r.tag           = st_tag;
		r.object_length = st_len;
		r.content_byte  = cb;
		r.arc_value     = arc;
		r.error_code    = e;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	function automatic res_t raise_error(err_t e);
		st_halted = 1'b1;
		return mk_res(KindError, 8'd0, 32'd0, e);
	endfunction

	function automatic res_t close_length(logic [31:0] next_off);
		logic [63:0] room;
		room = {32'd0, pr_buf_len} - {32'd0, next_off};
		if (st_len > room)
			return raise_error(ErrTruncated);
		st_left      = st_len;
		st_subid     = '0;
		st_first_arc = 1'b1;
		st_phase     = (st_len == 0) ? PhTag : PhContent;
		return mk_res(KindHeader, 8'd0, 32'd0, ErrNone);
	endfunction

	function automatic int decode_byte(logic [7:0] b, logic f, output res_t r0,
			output res_t r1, output bit parsed);
		int n;
		logic [31:0] p;
		logic [6:0] cnt;
		logic [31:0] s;
		n = 0;
		r0 = '0;
		r1 = '0;
		parsed = 1'b0;
		if (f) begin
			st_off       = '0;
			st_phase     = PhTag;
			st_halted    = 1'b0;
			st_subid     = '0;
			st_first_arc = 1'b1;
		end
		if (st_halted)
			return 0;
		p = st_off;
		if (st_phase == PhTag) begin
			if (p >= pr_buf_len)
				return 0;
			parsed = 1'b1;
			st_tag = b;
			st_len = '0;
			if (pr_buf_len - p < 2) begin
				r0 = raise_error(ErrTruncated);
				n = 1;
			end else begin
				st_off   = p + 1;
				st_phase = PhLen;
			end
		end else if (p >= pr_buf_len) begin
			parsed = 1'b1;
			r0 = raise_error(ErrTruncated);
			n = 1;
		end else begin
			parsed = 1'b1;
			st_off = p + 1;
			case (st_phase)
				PhLen: begin
					if (b[7]) begin
						cnt = b[6:0];
						st_len = '0;
						if (cnt > MaxLengthOctets) begin
							r0 = raise_error(ErrLenTooBig);
							n = 1;
						end else if (cnt == 0) begin
							r0 = close_length(st_off);
							n = 1;
						end else begin
							st_octs  = cnt[3:0];
							st_phase = PhLong;
						end
					end else begin
						st_len = 64'(b[6:0]);
						r0 = close_length(st_off);
						n = 1;
					end
				end
				PhLong: begin
					st_len  = {st_len[55:0], b};
					st_octs = st_octs - 1'b1;
					if (st_octs == 0) begin
						r0 = close_length(st_off);
						n = 1;
					end
				end
				default: begin
					if (pr_oid_on && st_tag == OidTag) begin
						st_subid = {st_subid[24:0], b[6:0]};
						if (!b[7]) begin
							s = st_subid;
							if (st_first_arc) begin
								r0 = mk_res(KindArc, 8'd0,
									(s < FirstArcLimit) ? s / FirstArcSplit : 32'd2, ErrNone);
								r1 = mk_res(KindArc, 8'd0,
									(s < FirstArcLimit) ? s % FirstArcSplit : s - FirstArcLimit,
									ErrNone);
								n = 2;
								st_first_arc = 1'b0;
							end else begin
								r0 = mk_res(KindArc, 8'd0, s, ErrNone);
								n = 1;
							end
							st_subid = '0;
						end
					end else begin
						r0 = mk_res(KindContent, b, 32'd0, ErrNone);
						n = 1;
					end
					st_left = st_left - 1;
					if (st_left == 0) begin
						st_phase     = PhTag;
						st_subid     = '0;
						st_first_arc = 1'b1;
					end
				end
			endcase
		end
		if (n == 1)
			r0.last_of_run = 1'b1;
		else if (n == 2)
			r1.last_of_run = 1'b1;
		return n;
	endfunction

	function automatic void cmp(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			n_fail++;
		end
	endfunction

	// one tlv object: mostly well formed, some with a broken length field
	function automatic void add_object();
		logic [7:0] tag_b;
		logic [7:0] body [$];
		logic [63:0] len;
		int cnt;
		int g;
		tag_b = ($urandom_range(0, 9) < 5) ? OidTag : 8'($urandom);
		if (tag_b == OidTag && $urandom_range(0, 4) != 0) begin
			repeat ($urandom_range(1, 4)) begin
				g = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : $urandom_range(1, 2);
				repeat (g - 1)
					body.push_back(8'h80 | 8'($urandom_range(0, 127)));
				body.push_back(8'($urandom_range(0, 127)));
			end
			if ($urandom_range(0, 9) == 0)
				body.push_back(8'h80 | 8'($urandom_range(0, 127)));
		end else begin
			repeat ($urandom_range(0, 12))
				body.push_back(8'($urandom));
		end
		len = body.size();
		buf_q.push_back(tag_b);
		case ($urandom_range(0, 9))
			0: buf_q.push_back(8'h80 | 8'($urandom_range(MaxLengthOctets + 1, 127)));
			1: begin
				cnt = $urandom_range(1, MaxLengthOctets);
				buf_q.push_back(8'h80 | 8'(cnt));
				repeat (cnt)
					buf_q.push_back(8'($urandom));
			end
			2, 3: begin
				cnt = $urandom_range(1, MaxLengthOctets);
				buf_q.push_back(8'h80 | 8'(cnt));
				for (int i = cnt - 1; i >= 0; i--)
					buf_q.push_back(8'(len >> (8 * i)));
			end
			4: buf_q.push_back((len == 0) ? 8'h80 : 8'(len));
			default: buf_q.push_back(8'(len));
		endcase
		foreach (body[i])
			buf_q.push_back(body[i]);
	endfunction

	function automatic void build_buffer(logic [31:0] blen);
		int target;
		buf_q.delete();
		if (blen > 4096) begin
			repeat ($urandom_range(1, 5))
				add_object();
			return;
		end
		target = blen;
		case ($urandom_range(0, 7))
			0: target = blen + $urandom_range(1, 3);
			1: if (blen > 1) target = blen - 1;
			default: ;
		endcase
		while (buf_q.size() < target)
			add_object();
		while (buf_q.size() > target)
			void'(buf_q.pop_back());
	endfunction

	task automatic send(logic f, logic [7:0] b, chk_t c);
		int gap;
		gap = $urandom_range(0, src_max);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		row_checks.push_back(c);
		byte_ch.valid           <= 1'b1;
		byte_ch.data_byte       <= b;
		byte_ch.first_of_buffer <= f;
		do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
	endtask

	task automatic settle();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (Settle) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		if (idx == RegBufferLength)
			pr_buf_len = v;
		else
			pr_oid_on = v[0];
		n_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : watch
		chk_t c;
		res_t r0, r1, e;
		bit parsed;
		int n;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				c = row_checks.pop_front();
				n = decode_byte(byte_ch.data_byte, byte_ch.first_of_buffer, r0, r1, parsed);
				n_bytes++;
				if (parsed)
					n_parsed++;
				if (c == ChkNone) begin
					n = 0;
				end else if (c != ChkPred) begin
					if (n == 0) begin
						r0 = '0;
						r0.last_of_run = 1'b1;
						n = 1;
					end
					r0.kind       = (c == ChkHeader) ? KindHeader : KindError;
					r0.error_code = (c == ChkHeader) ? ErrNone :
						(c == ChkTrunc) ? ErrTruncated : ErrLenTooBig;
				end
				if (n > 0)
					pending_results.push_back(r0);
				if (n > 1)
					pending_results.push_back(r1);
			end
			if (res_ch.valid && res_ch.ready) begin
				n_results++;
				kind_seen[res_ch.kind]++;
				if (pending_results.size() == 0) begin
					$error("result with nothing expected: kind %0d tag %0h",
						res_ch.kind, res_ch.tag);
					n_fail++;
				end else begin
					e = pending_results.pop_front();
					cmp("kind", e.kind, res_ch.kind);
					cmp("tag", e.tag, res_ch.tag);
					cmp("object_length", e.object_length, res_ch.object_length);
					cmp("content_byte", e.content_byte, res_ch.content_byte);
					cmp("arc_value", e.arc_value, res_ch.arc_value);
					cmp("error_code", e.error_code, res_ch.error_code);
					cmp("last_of_run", e.last_of_run, res_ch.last_of_run);
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				n_cycles, pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : sink
		int gap;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, snk_max);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	initial begin : stim
		logic [31:0] blen;
		logic [31:0] oid_w;
		logic [7:0] b;
		logic f;
		int unsigned bytes0;
		int sent;
		arst_n                  <= 1'b0;
		byte_ch.valid           <= 1'b0;
		byte_ch.data_byte       <= '0;
		byte_ch.first_of_buffer <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= RegBufferLength;
		cfg_wdata               <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].op == OpWrite) begin
				settle();
				write_reg(dir_tbl[i].idx, dir_tbl[i].val);
			end else begin
				send(dir_tbl[i].first, dir_tbl[i].val[7:0], dir_tbl[i].chk);
			end
		end

		bytes0 = n_bytes;
		while (n_bytes - bytes0 < RandBytes) begin
			settle();
			case ($urandom_range(0, 7))
				0: blen = 32'hFFFFFFFF;
				1: blen = $urandom;
				2: blen = $urandom_range(1, 3);
				default: blen = $urandom_range(4, 64);
			endcase
			oid_w = $urandom;
			oid_w[0] = ($urandom_range(0, 4) != 0);
			write_reg(RegBufferLength, blen);
			write_reg(RegDecodeOid, oid_w);
			src_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			snk_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			sent = 0;
			while (sent < PhaseBytes) begin
				build_buffer(blen);
				foreach (buf_q[i]) begin
					f = (i == 0) || ($urandom_range(0, 49) == 0);
					b = ($urandom_range(0, 49) == 0) ? 8'($urandom) : buf_q[i];
					send(f, b, ChkPred);
					sent++;
				end
			end
		end
		settle();

		$display("%0d bytes sent (%0d parsed), %0d register writes, %0d results checked",
			n_bytes, n_parsed, n_writes, n_results);
		$display("results: %0d headers, %0d content bytes, %0d oid arcs, %0d errors",
			kind_seen[KindHeader], kind_seen[KindContent], kind_seen[KindArc],
			kind_seen[KindError]);
		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
